// ===== rtl/core/bu2x_pkg.sv =====
// Shared constants and types for the 2x bilinear upscaler.
`default_nettype none

package bu2x_pkg;

	// Default maximum source dimensions
	localparam int unsigned DEF_MAX_COLS = 1024;
	localparam int unsigned DEF_MAX_ROWS = 1024;

	// Field widths
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COORD_W = 11;
	localparam int unsigned DIM_W   = 11;

	// Configuration port
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;
	localparam logic [DIM_W-1:0]     DIM_RESET      = 11'd1024;

	// Result slots of one source pixel, in emission order
	typedef enum logic [1:0] {
		SLOT_CENTRE = 2'd0,
		SLOT_VERT   = 2'd1,
		SLOT_HORIZ  = 2'd2,
		SLOT_COPY   = 2'd3
	} slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/bilinear_upscale_2x.sv =====
// Top level of the 2x bilinear upscaler with its line memory and result emitter.
// A pixel word is registered in stage 1 with its line memory read, then in the emitter
// once that is empty or gives its last result. Throughput: one result per cycle
// if out_ready is high; a pixel has 1 to 4 results; the next is taken while they drain.
// Reset clears counters, pipeline valids and neighbour registers; the line memory is
// not cleared, and its words only feed results at entries written earlier in the frame.
`default_nettype none

module bilinear_upscale_2x #(
	parameter int unsigned MAX_COLS = bu2x_pkg::DEF_MAX_COLS,
	parameter int unsigned MAX_ROWS = bu2x_pkg::DEF_MAX_ROWS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bu2x_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bu2x_pkg::DIM_W-1:0]      cfg_data,
	// source pixels
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [bu2x_pkg::PIX_W-1:0]      pixel,
	// upscaled pixels
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [bu2x_pkg::COORD_W-1:0]         out_row,
	output logic [bu2x_pkg::COORD_W-1:0]         out_col,
	output logic [bu2x_pkg::PIX_W-1:0]           value,
	output logic                                 last_of_run,
	output logic                                 frame_end
);

	localparam int unsigned CW   = $clog2(MAX_COLS);
	localparam int unsigned RW   = $clog2(MAX_ROWS);
	localparam int unsigned PW   = bu2x_pkg::PIX_W;
	localparam int unsigned DW   = bu2x_pkg::DIM_W;
	localparam int unsigned OW   = bu2x_pkg::COORD_W;
	localparam int unsigned CCMP = (CW + 1 > DW) ? CW + 1 : DW;
	localparam int unsigned RCMP = (RW + 1 > DW) ? RW + 1 : DW;

	// configuration registers
	logic [DW-1:0] image_rows_q;
	logic [DW-1:0] image_cols_q;

	// position and neighbour state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] left_q;
	logic [PW-1:0] upper_left_q;

	// line memory
	logic [PW-1:0] line_mem [MAX_COLS];

	// stage 1: accepted pixel with its memory read
	logic          valid_s1;
	logic [PW-1:0] pix_s1;
	logic [PW-1:0] left_s1;
	logic [PW-1:0] up_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [3:0]    mask_s1;
	logic          frame_s1;

	// result emitter
	logic [3:0]    em_mask_q;
	logic [CW-1:0] em_col_q;
	logic [RW-1:0] em_row_q;
	logic [PW-1:0] em_centre_q;
	logic [PW-1:0] em_vert_q;
	logic [PW-1:0] em_horiz_q;
	logic [PW-1:0] em_copy_q;
	logic          em_frame_q;

	logic            accept;
	logic            load;
	logic            pop;
	logic            last_col;
	logic            last_row;
	logic [PW+1:0]   centre_sum;
	logic [PW:0]     vert_sum;
	logic [PW:0]     horiz_sum;
	bu2x_pkg::slot_t slot;
	logic [RW:0]     row_x2;
	logic [CW:0]     col_x2;
	logic            odd_row;
	logic            odd_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= bu2x_pkg::DIM_RESET;
			image_cols_q <= bu2x_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == bu2x_pkg::REG_IMAGE_ROWS) begin
				image_rows_q <= cfg_data;
			end else if (cfg_index == bu2x_pkg::REG_IMAGE_COLS) begin
				image_cols_q <= cfg_data;
			end
		end
	end

	// end of row and frame, with zero acting as one and large values as the maximum
	assign last_col = (col_q == CW'(MAX_COLS - 1)) || (image_cols_q == '0) ||
		((CCMP'(col_q) + CCMP'(1)) >= CCMP'(image_cols_q));
	assign last_row = (row_q == RW'(MAX_ROWS - 1)) || (image_rows_q == '0) ||
		((RCMP'(row_q) + RCMP'(1)) >= RCMP'(image_rows_q));

	assign out_valid = |em_mask_q;
	assign pop       = out_valid && out_ready;
	assign load      = valid_s1 && (!out_valid || (pop && last_of_run));
	assign in_ready  = !valid_s1 || load;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= pixel;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read the previous row's word and replace it with the new one
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[col_q] <= pixel;
			up_s1           <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixel;
			left_s1  <= left_q;
			col_s1   <= col_q;
			row_s1   <= row_q;
			mask_s1  <= {1'b1, (col_q != '0), (row_q != '0), (row_q != '0) && (col_q != '0)};
			frame_s1 <= last_col && last_row;
		end
	end

	assign centre_sum = (PW+2)'(upper_left_q) + (PW+2)'(up_s1) + (PW+2)'(left_s1)
		+ (PW+2)'(pix_s1) + (PW+2)'(2);
	assign vert_sum   = (PW+1)'(up_s1) + (PW+1)'(pix_s1) + (PW+1)'(1);
	assign horiz_sum  = (PW+1)'(left_s1) + (PW+1)'(pix_s1) + (PW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_mask_q    <= '0;
			upper_left_q <= '0;
		end else if (load) begin
			em_mask_q    <= mask_s1;
			upper_left_q <= up_s1;
		end else if (pop) begin
			// drop the slot just delivered
			em_mask_q <= em_mask_q & (em_mask_q - 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			em_col_q    <= col_s1;
			em_row_q    <= row_s1;
			em_centre_q <= centre_sum[PW+1:2];
			em_vert_q   <= vert_sum[PW:1];
			em_horiz_q  <= horiz_sum[PW:1];
			em_copy_q   <= pix_s1;
			em_frame_q  <= frame_s1;
		end
	end

	always_comb begin
		priority if (em_mask_q[0]) begin
			slot = bu2x_pkg::SLOT_CENTRE;
		end else if (em_mask_q[1]) begin
			slot = bu2x_pkg::SLOT_VERT;
		end else if (em_mask_q[2]) begin
			slot = bu2x_pkg::SLOT_HORIZ;
		end else begin
			slot = bu2x_pkg::SLOT_COPY;
		end
	end

	always_comb begin
		unique case (slot)
			bu2x_pkg::SLOT_CENTRE: begin
				value   = em_centre_q;
				odd_row = 1'b1;
				odd_col = 1'b1;
			end
			bu2x_pkg::SLOT_VERT: begin
				value   = em_vert_q;
				odd_row = 1'b1;
				odd_col = 1'b0;
			end
			bu2x_pkg::SLOT_HORIZ: begin
				value   = em_horiz_q;
				odd_row = 1'b0;
				odd_col = 1'b1;
			end
			default: begin
				value   = em_copy_q;
				odd_row = 1'b0;
				odd_col = 1'b0;
			end
		endcase
	end

	assign row_x2      = {em_row_q, 1'b0};
	assign col_x2      = {em_col_q, 1'b0};
	assign out_row     = OW'(row_x2 - (RW+1)'(odd_row));
	assign out_col     = OW'(col_x2 - (CW+1)'(odd_col));
	assign last_of_run = (slot == bu2x_pkg::SLOT_COPY);
	assign frame_end   = last_of_run && em_frame_q;

endmodule

`default_nettype wire

// ===== rtl/core/bu2x_checker.sv =====
// Port-level checker for the 2x bilinear upscaler and its bind.
`default_nettype none

module bu2x_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [bu2x_pkg::COORD_W-1:0]   out_row,
	input wire logic [bu2x_pkg::COORD_W-1:0]   out_col,
	input wire logic [bu2x_pkg::PIX_W-1:0]     value,
	input wire logic                           last_of_run,
	input wire logic                           frame_end
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
			&& $stable(value) && $stable(last_of_run) && $stable(frame_end))
		else $error("stalled result word changed");

	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last_of_run)
		else $error("frame end on a word that does not close its run");

	// the copied source pixel closes every run
	a_copy_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_run == (!out_row[0] && !out_col[0])))
		else $error("run closed on the wrong word");

	// remaining words of a run follow without a gap
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run");

endmodule

bind bilinear_upscale_2x bu2x_checker u_bu2x_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_row     (out_row),
	.out_col     (out_col),
	.value       (value),
	.last_of_run (last_of_run),
	.frame_end   (frame_end)
);

`default_nettype wire
